@@ rtl/ray_segment_nearest_hit_top_assert.svh @@
// Assertion macros for the ray segment nearest hit block.
// Expects signals clk and arst_n in the scope of each use.
`ifndef RAY_SEGMENT_NEAREST_HIT_TOP_ASSERT_SVH
`define RAY_SEGMENT_NEAREST_HIT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define RSNH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked out of reset
`define RSNH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ rtl/rsnh_pkg.sv @@
// Shared types and constants for the ray segment nearest hit block.
// No dependencies; imported by every module of the block but rsnh_ram.
package rsnh_pkg;

	// configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_VIEWER_X = 2'd0;
	localparam logic [1:0] REG_VIEWER_Y = 2'd1;
	localparam logic [1:0] REG_ACTIVE   = 2'd2;
	localparam int         PADDR_W      = 4;

	// request actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_CAST = 1'b1;

	// quarter-wave sine polynomial, Q16 coefficients
	localparam logic [16:0] SIN_A     = 17'd102944;
	localparam logic [16:0] SIN_B     = 17'd42047;
	localparam logic [16:0] SIN_C     = 17'd4640;
	localparam logic [16:0] Q_ONE     = 17'd65536;
	localparam int          DIR_SCALE = 10;
	localparam logic [31:0] DIST_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic               action;
		logic [5:0]         entry_index;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic [7:0]         wall_texture;
		logic [11:0]        ray_angle;
		logic [9:0]         ray_number;
	} req_t;

	typedef struct packed {
		logic [9:0]         ray_index;
		logic               hit;
		logic [31:0]        distance;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [7:0]         hit_texture;
	} res_t;

	// one segment table word
	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic [7:0]         texture;
	} seg_t;

	// classified command passed from front to back
	typedef struct packed {
		logic        is_cast;
		logic [5:0]  slot;
		seg_t        seg;
		logic [1:0]  quad;
		logic [16:0] z;
		logic [9:0]  ray;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] viewer_x;
		logic signed [31:0] viewer_y;
		logic [6:0]         active_segments;
	} cfg_t;

endpackage

@@ rtl/rsnh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsnh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/rsnh_front.sv @@
// Front end: accepts requests, drops out-of-range loads, splits the ray angle.
// Depends on rsnh_pkg.
module rsnh_front #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic          req_valid,
	output logic          req_ready,
	input  rsnh_pkg::req_t req_data,
	input  logic          q_full,
	output logic          q_push,
	output rsnh_pkg::cmd_t q_data
);
	import rsnh_pkg::*;

	logic keep;

	// loads beyond the table are dropped, casts always go through
	assign keep      = (req_data.action == ACT_CAST) ||
		(int'(req_data.entry_index) < MAX_SEGMENTS);
	assign req_ready = !q_full;
	assign q_push    = req_valid && !q_full && keep;

	// quadrant and Q16 fraction of the quarter turn
	always_comb begin
		q_data             = '0;
		q_data.is_cast     = (req_data.action == ACT_CAST);
		q_data.slot        = req_data.entry_index;
		q_data.seg.start_x = req_data.start_x;
		q_data.seg.start_y = req_data.start_y;
		q_data.seg.end_x   = req_data.end_x;
		q_data.seg.end_y   = req_data.end_y;
		q_data.seg.texture = req_data.wall_texture;
		q_data.quad        = req_data.ray_angle[11:10];
		q_data.z           = {1'b0, req_data.ray_angle[9:0], 6'b0};
		q_data.ray         = req_data.ray_number;
	end

endmodule

@@ rtl/rsnh_queue.sv @@
// Two-entry command queue between front and back.
// Depends on rsnh_pkg.
module rsnh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsnh_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output rsnh_pkg::cmd_t pop_data
);
	import rsnh_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/rsnh_back.sv @@
// Back end: executes loads and casts; sine, intersection, serial divide and sqrt.
// Depends on rsnh_pkg, rsnh_ram and the assertion macro header.
`include "ray_segment_nearest_hit_top_assert.svh"
module rsnh_back #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rsnh_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  rsnh_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output rsnh_pkg::res_t res_data
);
	import rsnh_pkg::*;

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = ($clog2(MAX_SEGMENTS + 1) > 7) ? $clog2(MAX_SEGMENTS + 1) : 7;
	localparam logic [CW-1:0] SEG_LIMIT = CW'(MAX_SEGMENTS);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_SQ   = 5'd1;
	localparam logic [4:0] ST_SC   = 5'd2;
	localparam logic [4:0] ST_SB   = 5'd3;
	localparam logic [4:0] ST_SA   = 5'd4;
	localparam logic [4:0] ST_SE   = 5'd5;
	localparam logic [4:0] ST_RD   = 5'd6;
	localparam logic [4:0] ST_LD   = 5'd7;
	localparam logic [4:0] ST_M1   = 5'd8;
	localparam logic [4:0] ST_M2   = 5'd9;
	localparam logic [4:0] ST_M3   = 5'd10;
	localparam logic [4:0] ST_M4   = 5'd11;
	localparam logic [4:0] ST_M5   = 5'd12;
	localparam logic [4:0] ST_CK   = 5'd13;
	localparam logic [4:0] ST_P0   = 5'd14;
	localparam logic [4:0] ST_P1   = 5'd15;
	localparam logic [4:0] ST_P2   = 5'd16;
	localparam logic [4:0] ST_P3   = 5'd17;
	localparam logic [4:0] ST_DIV  = 5'd18;
	localparam logic [4:0] ST_BOX  = 5'd19;
	localparam logic [4:0] ST_SQ2  = 5'd20;
	localparam logic [4:0] ST_SUM  = 5'd21;
	localparam logic [4:0] ST_SQI  = 5'd22;
	localparam logic [4:0] ST_SQRT = 5'd23;
	localparam logic [4:0] ST_CMP  = 5'd24;
	localparam logic [4:0] ST_NEXT = 5'd25;
	localparam logic [4:0] ST_OUT  = 5'd26;

	logic [4:0] state_q, state_d;
	logic       res_valid_q;
	res_t       res_q;

	// segment table
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_raddr;
	seg_t          ram_rdata;

	// cast context
	logic [9:0]         ray_q;
	logic [1:0]         quad_q;
	logic [16:0]        zin_q, z_q, z2_q, s0_q;
	logic               which_q;
	logic signed [20:0] dx_q, dy_q;
	logic [CW-1:0]      n_q, seg_idx_q;

	// segment working set
	logic signed [31:0] minx_q, maxx_q, miny_q, maxy_q;
	logic [7:0]         tex_q;
	logic signed [32:0] sx_q, sy_q, wx_q, wy_q;
	logic signed [67:0] p1_q;
	logic signed [54:0] den_q;
	logic signed [66:0] num_q;
	logic [65:0]        nmag_q;
	logic [54:0]        dmag_q;
	logic               axis_q;
	logic [52:0]        lo_q;
	logic [86:0]        pw_q;
	logic [54:0]        rem_q;
	logic [31:0]        quo_q, qx_q, qy_q;
	logic [4:0]         cnt_q;
	logic signed [31:0] hx_q, hy_q;
	logic [63:0]        sqx_q, v_q, root_q, one_q;
	logic [64:0]        sum_q;
	logic [31:0]        dist_q;

	// running best
	logic               found_q;
	logic [31:0]        best_d_q;
	logic signed [31:0] best_x_q, best_y_q;
	logic [7:0]         best_tex_q;

	// shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_q;

	logic [16:0]        z2_c, tb_c, ta_c, tv_c, sv_c;
	logic signed [17:0] sn_c, cs_c;
	logic               ck_skip, p_ovf, in_box, better;
	logic [65:0]        nmag_c;
	logic [54:0]        dmag_c;
	logic signed [20:0] dsel, dabs;
	logic [19:0]        m_c;
	logic [55:0]        rsh, rdiff;
	logic               dge;
	logic [54:0]        rem_nx;
	logic [31:0]        quo_nx;
	logic signed [33:0] ox_c, oy_c, hx_c, hy_c;
	logic [63:0]        sq_t, root_nx;
	logic               sq_ge;
	logic               out_load;
	logic [CW-1:0]      n_c;

	rsnh_ram #(
		.WIDTH ($bits(seg_t)),
		.DEPTH (MAX_SEGMENTS)
	) u_seg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.slot)),
		.wdata (cmd.seg),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign ram_we    = cmd_pop && !cmd.is_cast;
	assign ram_re    = (state_q == ST_RD);
	assign ram_raddr = AW'(seg_idx_q);
	assign out_load  = (state_q == ST_OUT) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign n_c = (CW'(cfg.active_segments) > SEG_LIMIT) ? SEG_LIMIT :
		CW'(cfg.active_segments);

	// sine polynomial terms
	always_comb begin
		z2_c = mul_q[32:16];
		tb_c = SIN_B - {4'b0, mul_q[28:16]};
		ta_c = SIN_A - {1'b0, mul_q[31:16]};
		tv_c = mul_q[32:16];
		sv_c = (tv_c > Q_ONE) ? Q_ONE : tv_c;
		unique case (quad_q)
			2'd0: begin
				sn_c = {1'b0, s0_q};
				cs_c = {1'b0, sv_c};
			end
			2'd1: begin
				sn_c = {1'b0, sv_c};
				cs_c = -{1'b0, s0_q};
			end
			2'd2: begin
				sn_c = -{1'b0, s0_q};
				cs_c = -{1'b0, sv_c};
			end
			default: begin
				sn_c = -{1'b0, sv_c};
				cs_c = {1'b0, s0_q};
			end
		endcase
	end

	// intersection checks, divider and square root steps
	always_comb begin
		ck_skip = (den_q == '0) || ((num_q != '0) && (num_q[66] != den_q[54]));
		nmag_c  = num_q[66] ? 66'(-num_q) : num_q[65:0];
		dmag_c  = den_q[54] ? 55'(-den_q) : 55'(den_q);
		dsel    = axis_q ? dy_q : dx_q;
		dabs    = dsel[20] ? -dsel : dsel;
		m_c     = dabs[19:0];
		p_ovf   = pw_q[86:32] >= {1'b0, dmag_q};
		rsh     = {rem_q, quo_q[31]};
		rdiff   = rsh - {1'b0, dmag_q};
		dge     = rsh >= {1'b0, dmag_q};
		rem_nx  = dge ? rdiff[54:0] : rsh[54:0];
		quo_nx  = {quo_q[30:0], dge};
		ox_c    = dx_q[20] ? -$signed({2'b0, qx_q}) : $signed({2'b0, qx_q});
		oy_c    = dy_q[20] ? -$signed({2'b0, qy_q}) : $signed({2'b0, qy_q});
		hx_c    = 34'(cfg.viewer_x) + ox_c;
		hy_c    = 34'(cfg.viewer_y) + oy_c;
		in_box  = (hx_c >= 34'(minx_q)) && (hx_c <= 34'(maxx_q)) &&
			(hy_c >= 34'(miny_q)) && (hy_c <= 34'(maxy_q));
		sq_t    = root_q + one_q;
		sq_ge   = v_q >= sq_t;
		root_nx = sq_ge ? ((root_q >> 1) + one_q) : (root_q >> 1);
		better  = !found_q || (dist_q < best_d_q);
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = {17'b0, z_q};
				mul_b = {17'b0, z_q};
			end
			ST_SC: begin
				mul_a = {17'b0, SIN_C};
				mul_b = {17'b0, z2_c};
			end
			ST_SB: begin
				mul_a = {17'b0, tb_c};
				mul_b = {17'b0, z2_q};
			end
			ST_SA: begin
				mul_a = {17'b0, ta_c};
				mul_b = {17'b0, z_q};
			end
			ST_M1: begin
				mul_a = 34'(dx_q);
				mul_b = 34'(sy_q);
			end
			ST_M2: begin
				mul_a = 34'(dy_q);
				mul_b = 34'(sx_q);
			end
			ST_M3: begin
				mul_a = 34'(wx_q);
				mul_b = 34'(sy_q);
			end
			ST_M4: begin
				mul_a = 34'(wy_q);
				mul_b = 34'(sx_q);
			end
			ST_P0: begin
				mul_a = {1'b0, nmag_q[32:0]};
				mul_b = {14'b0, m_c};
			end
			ST_P1: begin
				mul_a = {1'b0, nmag_q[65:33]};
				mul_b = {14'b0, m_c};
			end
			ST_BOX: begin
				mul_a = {2'b0, qx_q};
				mul_b = {2'b0, qx_q};
			end
			ST_SQ2: begin
				mul_a = {2'b0, qy_q};
				mul_b = {2'b0, qy_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_valid && cmd.is_cast) begin
				state_d = ST_SQ;
			end
			ST_SQ:  state_d = ST_SC;
			ST_SC:  state_d = ST_SB;
			ST_SB:  state_d = ST_SA;
			ST_SA:  state_d = ST_SE;
			ST_SE:  state_d = which_q ? ST_RD : ST_SQ;
			ST_RD:  state_d = (seg_idx_q >= n_q) ? ST_OUT : ST_LD;
			ST_LD:  state_d = ST_M1;
			ST_M1:  state_d = ST_M2;
			ST_M2:  state_d = ST_M3;
			ST_M3:  state_d = ST_M4;
			ST_M4:  state_d = ST_M5;
			ST_M5:  state_d = ST_CK;
			ST_CK:  state_d = ck_skip ? ST_NEXT : ST_P0;
			ST_P0:  state_d = ST_P1;
			ST_P1:  state_d = ST_P2;
			ST_P2:  state_d = ST_P3;
			ST_P3:  state_d = p_ovf ? ST_NEXT : ST_DIV;
			ST_DIV: if (cnt_q == 5'd0) begin
				state_d = axis_q ? ST_BOX : ST_P0;
			end
			ST_BOX: state_d = in_box ? ST_SQ2 : ST_NEXT;
			ST_SQ2: state_d = ST_SUM;
			ST_SUM: state_d = ST_SQI;
			ST_SQI: state_d = sum_q[64] ? ST_CMP : ST_SQRT;
			ST_SQRT: if (one_q[0]) begin
				state_d = ST_CMP;
			end
			ST_CMP:  state_d = ST_NEXT;
			ST_NEXT: state_d = ST_RD;
			ST_OUT: if (out_load) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: if (cmd_valid && cmd.is_cast) begin
				ray_q      <= cmd.ray;
				quad_q     <= cmd.quad;
				zin_q      <= cmd.z;
				z_q        <= cmd.z;
				which_q    <= 1'b0;
				n_q        <= n_c;
				found_q    <= 1'b0;
				best_d_q   <= DIST_MAX;
				best_x_q   <= '0;
				best_y_q   <= '0;
				best_tex_q <= '0;
			end
			ST_SC: z2_q <= z2_c;
			ST_SE: if (!which_q) begin
				s0_q    <= sv_c;
				which_q <= 1'b1;
				z_q     <= Q_ONE - zin_q;
			end else begin
				dx_q      <= 21'(cs_c) * 21'(DIR_SCALE);
				dy_q      <= 21'(sn_c) * 21'(DIR_SCALE);
				seg_idx_q <= '0;
			end
			ST_LD: begin
				sx_q   <= 33'(ram_rdata.end_x) - 33'(ram_rdata.start_x);
				sy_q   <= 33'(ram_rdata.end_y) - 33'(ram_rdata.start_y);
				wx_q   <= 33'(ram_rdata.start_x) - 33'(cfg.viewer_x);
				wy_q   <= 33'(ram_rdata.start_y) - 33'(cfg.viewer_y);
				minx_q <= (ram_rdata.start_x < ram_rdata.end_x) ?
					ram_rdata.start_x : ram_rdata.end_x;
				maxx_q <= (ram_rdata.start_x < ram_rdata.end_x) ?
					ram_rdata.end_x : ram_rdata.start_x;
				miny_q <= (ram_rdata.start_y < ram_rdata.end_y) ?
					ram_rdata.start_y : ram_rdata.end_y;
				maxy_q <= (ram_rdata.start_y < ram_rdata.end_y) ?
					ram_rdata.end_y : ram_rdata.start_y;
				tex_q  <= ram_rdata.texture;
			end
			ST_M2: p1_q  <= mul_q;
			ST_M3: den_q <= p1_q[54:0] - mul_q[54:0];
			ST_M4: p1_q  <= mul_q;
			ST_M5: num_q <= p1_q[66:0] - mul_q[66:0];
			ST_CK: begin
				nmag_q <= nmag_c;
				dmag_q <= dmag_c;
				axis_q <= 1'b0;
			end
			ST_P1: lo_q <= mul_q[52:0];
			ST_P2: pw_q <= {mul_q[53:0], 33'b0} + {34'b0, lo_q};
			ST_P3: begin
				rem_q <= pw_q[86:32];
				quo_q <= pw_q[31:0];
				cnt_q <= 5'd31;
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					if (axis_q) begin
						qy_q <= quo_nx;
					end else begin
						qx_q   <= quo_nx;
						axis_q <= 1'b1;
					end
				end
			end
			ST_BOX: begin
				hx_q <= hx_c[31:0];
				hy_q <= hy_c[31:0];
			end
			ST_SQ2: sqx_q <= mul_q[63:0];
			ST_SUM: sum_q <= {1'b0, sqx_q} + {1'b0, mul_q[63:0]};
			ST_SQI: begin
				v_q    <= sum_q[63:0];
				root_q <= '0;
				one_q  <= 64'h4000_0000_0000_0000;
				dist_q <= DIST_MAX;
			end
			ST_SQRT: begin
				if (sq_ge) begin
					v_q <= v_q - sq_t;
				end
				root_q <= root_nx;
				one_q  <= one_q >> 2;
				if (one_q[0]) begin
					dist_q <= root_nx[31:0];
				end
			end
			ST_CMP: if (better) begin
				found_q    <= 1'b1;
				best_d_q   <= dist_q;
				best_x_q   <= hx_q;
				best_y_q   <= hy_q;
				best_tex_q <= tex_q;
			end
			ST_NEXT: seg_idx_q <= seg_idx_q + CW'(1);
			default: begin
			end
		endcase
		// hold the result until taken
		if (out_load) begin
			res_q.ray_index   <= ray_q;
			res_q.hit         <= found_q;
			res_q.distance    <= best_d_q;
			res_q.point_x     <= best_x_q;
			res_q.point_y     <= best_y_q;
			res_q.hit_texture <= best_tex_q;
		end
	end

	`RSNH_ASSERT_IMP(a_pop_in_idle, cmd_pop, state_q == ST_IDLE, "command popped while busy")
	`RSNH_ASSERT_IMP(a_div_rem, state_q == ST_DIV, rem_q < dmag_q, "divider remainder out of range")
	`RSNH_ASSERT_IMP(a_seg_bound, (state_q == ST_RD) || (state_q == ST_LD), seg_idx_q <= n_q, "segment index past count")
	`RSNH_ASSERT_NXT(a_out_held, res_valid_q && !res_ready, res_valid_q, "result dropped before taken")

endmodule

@@ rtl/ray_segment_nearest_hit_top.sv @@
// Top level of the ray segment nearest hit block: config registers, front, queue, back.
// Depends on rsnh_pkg, rsnh_front, rsnh_queue, rsnh_back.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (req_t)
//  res     | out       | res_valid/res_ready  | res_data (res_t)
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// A cast's run time grows with the number n of active segments, set by the serial
// 32-step divider (one per axis) and 32-step square root per segment.
// Reset clears control state; the segment table is undefined until loaded.
// The two-entry queue lets requests arrive while a cast runs; a waiting result
// stalls only the next cast at its end.
module ray_segment_nearest_hit_top #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  rsnh_pkg::req_t                req_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output rsnh_pkg::res_t                res_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rsnh_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import rsnh_pkg::*;

	cfg_t cfg_q;
	logic q_full, q_push, q_valid, q_pop;
	cmd_t q_in, q_out;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_VIEWER_X: cfg_q.viewer_x        <= pwdata;
				REG_VIEWER_Y: cfg_q.viewer_y        <= pwdata;
				REG_ACTIVE:   cfg_q.active_segments <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// configuration reads
	always_comb begin
		unique case (paddr[3:2])
			REG_VIEWER_X: prdata = cfg_q.viewer_x;
			REG_VIEWER_Y: prdata = cfg_q.viewer_y;
			REG_ACTIVE:   prdata = {25'b0, cfg_q.active_segments};
			default:      prdata = '0;
		endcase
	end

	rsnh_front #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	rsnh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_out)
	);

	rsnh_back #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd       (q_out),
		.cmd_pop   (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule
